@@ design/mvws_pkg.sv @@
// Package with the shared types, codes and wave helpers of the voice synthesizer.
`timescale 1ns / 1ps
package mvws_pkg;

    typedef enum logic [2:0] {
        MODE_READ    = 3'd0,
        MODE_WRITE   = 3'd1,
        MODE_TICK16  = 3'd2,
        MODE_TICK32  = 3'd3,
        MODE_TICK0   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        BANK_CTRL = 2'd0,
        BANK_AUXB = 2'd1,
        BANK_AUXC = 2'd2,
        BANK_ACC  = 2'd3
    } t_bank;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_ADV_RD_E,
        ST_ADV_RD_O,
        ST_ADV_WR_E,
        ST_ADV_WR_O,
        ST_MIX_RD_O,
        ST_MIX_MOD,
        ST_MIX_RD_E,
        ST_MIX_CAR,
        ST_CLAMP,
        ST_DONE
    } t_state;

    localparam logic [31:0] C_PCM_BIT   = 32'h0010_0000;
    localparam logic [31:0] C_FREQ_MASK = 32'h000F_FFFF;
    localparam logic [31:0] C_FM_BIT    = 32'h0020_0000;
    localparam logic [5:0]  C_ATT_MUTE  = 6'd63;
    localparam logic [15:0] C_HALF      = 16'h8000;
    localparam logic [15:0] C_ONES      = 16'hFFFF;
    localparam int          C_SMP_MIN   = -32768;
    localparam int          C_SMP_MAX   = 32767;

    // Wave shape and attenuation of one voice from its control word and phase.
    function automatic logic signed [15:0] voice_wave(input logic [31:0] c,
                                                       input logic [31:0] acc);
        logic [15:0] p0, p1, m, w;
        logic signed [15:0] s;
        logic signed [20:0] prod;
        logic [5:0] a;
        p0 = acc[19:4];
        p1 = acc[18:3];
        m  = acc[19] ? C_ONES : 16'h0000;
        case (c[30:28])
            3'd1: begin w = p1 ^ m; if (w < C_HALF) w = C_HALF; end
            3'd2: begin w = p1 ^ m; if (w < C_HALF) w = w ^ C_ONES; end
            3'd3: begin w = p1; if (w < C_HALF) w = C_HALF; end
            3'd5: w = p1;
            3'd6: w = m;
            3'd7: w = p0 ^ (p0 << 3) ^ (p0 << 7);
            default: w = p1 ^ m;
        endcase
        s = $signed(w ^ C_HALF);
        a = c[27:22];
        prod = s * $signed({1'b0, 5'd16 - {2'b00, a[2:0]}});
        prod = prod >>> 4;
        prod = prod >>> a[5:3];
        if (c == 32'h0 || a == C_ATT_MUTE) voice_wave = 16'sd0;
        else voice_wave = prod[15:0];
    endfunction

endpackage

@@ design/mvws_regfile.sv @@
// Register memories: control banks and phase accumulators behind one shared port.
`timescale 1ns / 1ps
module mvws_regfile #(
    parameter int NUM_VOICES = 32,
    parameter int VW = 6
) (
    input  logic          i_clk,
    input  logic [VW-1:0] i_addr,
    input  logic [1:0]    i_bank,
    input  logic          i_we,
    input  logic [31:0]   i_wdata,
    output logic [31:0]   o_rdata
);
    import mvws_pkg::*;

    logic [31:0] r_ctrl [NUM_VOICES];
    logic [31:0] r_auxb [NUM_VOICES];
    logic [31:0] r_auxc [NUM_VOICES];
    logic [31:0] r_acc  [NUM_VOICES];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            case (t_bank'(i_bank))
                BANK_CTRL: r_ctrl[i_addr] <= i_wdata;
                BANK_AUXB: r_auxb[i_addr] <= i_wdata;
                BANK_AUXC: r_auxc[i_addr] <= i_wdata;
                default:   r_acc[i_addr]  <= i_wdata;
            endcase
        end
        case (t_bank'(i_bank))
            BANK_CTRL: r_rdata <= r_ctrl[i_addr];
            BANK_AUXB: r_rdata <= r_auxb[i_addr];
            BANK_AUXC: r_rdata <= r_auxc[i_addr];
            default:   r_rdata <= r_acc[i_addr];
        endcase
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/multi_voice_wave_synth_top.sv @@
// Top level of the multi-voice wave synthesizer: sequencer, clearing pass and mixer.
`timescale 1ns / 1ps
// Channel | Direction | Signals
// input   | in        | i_valid, o_ready, i_mode, i_reg_index, i_write_value
// output  | out       | o_valid, i_ready, o_read_data, o_mix_sample
//
// After reset a clearing pass writes zero to every entry of all four banks,
// while o_ready stays low.
// A tick walks the voice pairs through one shared memory port: each pair is
// gathered and written back to advance, except on MODE_TICK0, and gathered
// once for the modulator and once for the carrier to mix; the single memory port sets the rate.
// A result waits in the output register; the next request is taken once it
// has been delivered.
module multi_voice_wave_synth_top #(
    parameter int NUM_VOICES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [6:0]  i_reg_index,
    input  logic [31:0] i_write_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_read_data,
    output logic signed [15:0] o_mix_sample
);
    import mvws_pkg::*;

    localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CW = $clog2(4 * NUM_VOICES + 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_clr;
    logic          r_clearing;
    logic [2:0]    r_mode;
    logic [6:0]    r_idx;
    logic [31:0]   r_wval;
    logic [VW:0]   r_pair;       // even voice number of the current pair
    logic [1:0]    r_sh;
    logic [31:0]   r_ce, r_co, r_ae, r_ao;
    logic signed [15:0] r_modw;
    logic signed [21:0] r_sum;
    logic [31:0]   r_rd;
    logic signed [15:0] r_smp;
    logic          r_oval;

    // Memory port, driven by the sequencer.
    logic [VW-1:0] m_addr;
    logic [1:0]    m_bank;
    logic          m_we;
    logic [31:0]   m_wdata, m_rdata;

    mvws_regfile #(.NUM_VOICES(NUM_VOICES), .VW(VW)) u_rf (
        .i_clk(i_clk), .i_addr(m_addr), .i_bank(m_bank), .i_we(m_we),
        .i_wdata(m_wdata), .o_rdata(m_rdata)
    );

    logic        in_fire;
    logic [VW:0] odd_v;
    logic        odd_ok, last_pair, voice_ok;
    logic [31:0] adv_a, adv_o;

    assign o_ready  = (r_state == ST_IDLE) && !r_clearing && !r_oval;
    assign in_fire  = i_valid && o_ready;
    assign odd_v    = r_pair + 1'b1;
    assign odd_ok   = odd_v < (VW+1)'(NUM_VOICES);
    assign last_pair = (r_pair + 2'd2) >= (VW+1)'(NUM_VOICES);
    assign voice_ok = {2'b00, r_idx[6:2]} < 7'(NUM_VOICES);

    // Pair advance arithmetic on the gathered words.
    always_comb begin
        adv_a = r_ae + ((r_ce & C_FREQ_MASK) << r_sh);
        if ((r_ce & C_PCM_BIT) != 0 && odd_ok)
            adv_o = (r_co & C_PCM_BIT) != 0 ? r_ao - {12'h0, adv_a[31:20]}
                                           : r_ao + {12'h0, adv_a[31:20]};
        else
            adv_o = r_ao + (r_co << r_sh);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (in_fire) begin
                             if (i_mode == MODE_READ || i_mode == MODE_WRITE)
                                 n_state = ST_ACCESS;
                             else if (i_mode == MODE_TICK16 || i_mode == MODE_TICK32)
                                 n_state = ST_ADV_RD_E;
                             else if (i_mode == MODE_TICK0)
                                 n_state = ST_MIX_RD_O;
                             else
                                 n_state = ST_DONE;
                         end
            ST_ACCESS:   n_state = ST_DONE;
            ST_ADV_RD_E: n_state = ST_ADV_RD_O;
            ST_ADV_RD_O: n_state = ST_ADV_WR_E;
            ST_ADV_WR_E: n_state = ST_ADV_WR_O;
            ST_ADV_WR_O: n_state = last_pair ? ST_MIX_RD_O : ST_ADV_RD_E;
            ST_MIX_RD_O: n_state = ST_MIX_MOD;
            ST_MIX_MOD:  n_state = ST_MIX_RD_E;
            ST_MIX_RD_E: n_state = ST_MIX_CAR;
            ST_MIX_CAR:  n_state = last_pair ? ST_CLAMP : ST_MIX_RD_O;
            ST_CLAMP:    n_state = ST_DONE;
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Memory port control. Each gather state issues four reads over the
    // sub-phases held in r_phase; see below.
    logic [2:0] r_phase;
    logic       gather;
    assign gather = (r_state == ST_ADV_RD_E) || (r_state == ST_MIX_RD_O)
                 || (r_state == ST_MIX_RD_E);

    always_comb begin
        m_addr  = r_pair[VW-1:0];
        m_bank  = BANK_CTRL;
        m_we    = 1'b0;
        m_wdata = r_wval;
        if (r_clearing) begin
            m_addr  = r_clr[VW+1:2];
            m_bank  = r_clr[1:0];
            m_we    = 1'b1;
            m_wdata = '0;
        end else begin
            case (r_state)
                ST_ACCESS: begin
                    m_addr = VW'(r_idx[6:2]);
                    m_bank = r_idx[1:0];
                    m_we   = (r_mode == MODE_WRITE) && voice_ok;
                end
                ST_ADV_RD_E, ST_MIX_RD_O, ST_MIX_RD_E: begin
                    m_addr = (r_phase[1] && odd_ok) ? odd_v[VW-1:0] : r_pair[VW-1:0];
                    m_bank = r_phase[0] ? BANK_ACC : BANK_CTRL;
                end
                ST_ADV_WR_E: begin
                    m_bank  = BANK_ACC;
                    m_we    = 1'b1;
                    m_wdata = ((r_ce & C_PCM_BIT) != 0 && odd_ok) ? (adv_a & C_FREQ_MASK)
                                                                 : r_ae + (r_ce << r_sh);
                end
                ST_ADV_WR_O: begin
                    m_addr  = odd_v[VW-1:0];
                    m_bank  = BANK_ACC;
                    m_we    = odd_ok;
                    m_wdata = adv_o;
                end
                default: ;
            endcase
        end
    end

    // Registers. Gather states hold through their sub-phases: four reads then settle.
    logic hold;
    assign hold = gather && r_phase != 3'd4;

    logic [31:0] modacc;
    logic signed [15:0] wv_odd, wv_even;
    logic fm, pcm;
    assign fm  = r_ce[21];
    // A set carry bit on the even voice silences its pair, and an unpaired
    // last voice still sounds, with nothing added for its missing partner.
    assign pcm = (r_ce & C_PCM_BIT) != 0;
    assign modacc = r_ae + {{11{r_modw[15]}}, r_modw, 5'b0};
    assign wv_odd  = voice_wave(odd_ok ? r_co : 32'h0, r_ao);
    assign wv_even = voice_wave(r_ce, fm ? modacc : r_ae);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_clearing <= 1'b1;
            r_clr      <= '0;
            r_oval     <= 1'b0;
            r_phase    <= '0;
        end else begin
            if (r_clearing) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == CW'(4 * NUM_VOICES - 1)) r_clearing <= 1'b0;
            end
            if (hold) r_phase <= r_phase + 1'b1;
            else begin
                r_phase <= '0;
                r_state <= n_state;
            end
            if (r_state == ST_DONE) r_oval <= 1'b1;
            else if (r_oval && i_ready) r_oval <= 1'b0;
        end
        // Data captured from the registered read port in the cycle after each address.
        if (gather && r_phase != 3'd0) begin
            case (r_phase)
                3'd1: r_ce <= m_rdata;
                3'd2: r_ae <= m_rdata;
                3'd3: r_co <= odd_ok ? m_rdata : 32'h0;
                default: r_ao <= odd_ok ? m_rdata : 32'h0;
            endcase
        end
        if (in_fire) begin
            r_mode <= i_mode;
            r_idx  <= i_reg_index;
            r_wval <= i_write_value;
            r_pair <= '0;
            r_sum  <= '0;
            r_rd   <= '0;
            r_smp  <= '0;
            r_sh   <= (i_mode == MODE_TICK16) ? 2'd2 : 2'd1;
        end
        if (r_state == ST_DONE && r_mode == MODE_READ && voice_ok)
            r_rd <= (r_idx[1:0] == BANK_ACC) ? (m_rdata & C_FREQ_MASK) : m_rdata;
        if (r_state == ST_ADV_WR_O && last_pair) r_pair <= '0;
        else if (r_state == ST_ADV_WR_O || r_state == ST_MIX_CAR) r_pair <= r_pair + 2'd2;
        if (r_state == ST_MIX_MOD) r_modw <= wv_odd;
        if (r_state == ST_MIX_CAR && !pcm)
            r_sum <= r_sum + 22'(wv_even) + ((fm || !odd_ok) ? 22'sd0 : 22'(r_modw));
        if (r_state == ST_CLAMP) begin
            if (r_sum < 22'(C_SMP_MIN)) r_smp <= 16'sh8000;
            else if (r_sum > 22'(C_SMP_MAX)) r_smp <= 16'sh7FFF;
            else r_smp <= r_sum[15:0];
        end
    end

    assign o_valid      = r_oval;
    assign o_read_data  = r_rd;
    assign o_mix_sample = r_smp;

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_ready) else $error("request taken during clear");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_ready) else $error("ready while busy");
endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the multi-voice wave synthesizer top level.
`timescale 1ns / 1ps
module tb_top;
    import mvws_pkg::*;

    localparam int NV        = 32;
    localparam int N_RANDOM  = 1680;
    localparam int MAX_ERRS  = 10;
    // A generous ceiling over the whole run, ticks with stalls included.
    localparam int CYCLE_CAP = 3000000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [6:0]  idx;
        logic [31:0] val;
    } t_request;

    typedef struct packed {
        logic [31:0]        rd;
        logic signed [15:0] smp;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_mode;
    logic [6:0]  i_reg_index;
    logic [31:0] i_write_value;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_read_data;
    logic signed [15:0] o_mix_sample;

    multi_voice_wave_synth_top #(.NUM_VOICES(NV)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode), .i_reg_index(i_reg_index), .i_write_value(i_write_value),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_read_data(o_read_data), .o_mix_sample(o_mix_sample)
    );

    // Shadow copy of the register banks and accumulators.
    logic [31:0] sh_ctrl [NV];
    logic [31:0] sh_auxb [NV];
    logic [31:0] sh_auxc [NV];
    logic [31:0] sh_acc  [NV];

    t_request pending_reqs[$];
    t_answer  expected_answers[$];
    int       mismatches;
    int       cycle_count;
    bit       stim_done;
    bit       calm;        // last part of the run: no idling on either side
    bit       hold_sender; // sender holds off until everything has come back
    int       drv_gap;
    int       mon_stall;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Arithmetic shift right of a signed 32-bit value.
    function automatic int shr_signed(int v, int s);
        return v >>> s;
    endfunction

    // Output of one voice; modulation is applied only when not acting as modulator.
    function automatic int voice_output(int vn, bit as_mod);
        logic [31:0] c, acc, p0, p1, m, w;
        int mv, sv, a;
        c = sh_ctrl[vn];
        if (c == 32'h0) return 0;
        acc = sh_acc[vn];
        if (!as_mod && sh_ctrl[vn & ~1][21]) begin
            if (vn & 1) return 0;
            mv = ((vn | 1) < NV) ? voice_output(vn | 1, 1'b1) : 0;
            acc = acc + 32'(mv * 32);
        end
        p0 = (acc >> 4) & 32'hFFFF;
        p1 = (acc >> 3) & 32'hFFFF;
        m  = acc[19] ? 32'hFFFF : 32'h0;
        case (c[30:28])
            3'd1: begin w = p1 ^ m; if (w < 32'h8000) w = 32'h8000; end
            3'd2: begin w = p1 ^ m; if (w < 32'h8000) w = w ^ 32'hFFFF; end
            3'd3: begin w = p1; if (w < 32'h8000) w = 32'h8000; end
            3'd5: w = p1;
            3'd6: w = m;
            3'd7: w = (p0 ^ (p0 << 3) ^ (p0 << 7)) & 32'hFFFF;
            default: w = p1 ^ m;
        endcase
        w = (w ^ 32'h8000) & 32'hFFFF;
        sv = int'(w) - (w[15] ? 32'h10000 : 0);
        a = int'(c[27:22]);
        if (a == 63) return 0;
        sv = shr_signed(sv * (16 - (a & 7)), 4);
        return shr_signed(sv, a >> 3);
    endfunction

    // Step accumulators by ctrl << sh; a carry pair carries from even into odd.
    function automatic void step_phases(int sh);
        logic [31:0] a;
        for (int e = 0; e + 1 < NV; e += 2) begin
            if (sh_ctrl[e][20]) begin
                a = sh_acc[e] + ((sh_ctrl[e] & 32'h000F_FFFF) << sh);
                if (sh_ctrl[e + 1][20]) sh_acc[e + 1] = sh_acc[e + 1] - (a >> 20);
                else sh_acc[e + 1] = sh_acc[e + 1] + (a >> 20);
                sh_acc[e] = a & 32'h000F_FFFF;
            end else begin
                sh_acc[e]     = sh_acc[e] + (sh_ctrl[e] << sh);
                sh_acc[e + 1] = sh_acc[e + 1] + (sh_ctrl[e + 1] << sh);
            end
        end
        if (NV % 2 == 1) sh_acc[NV - 1] = sh_acc[NV - 1] + (sh_ctrl[NV - 1] << sh);
    endfunction

    function automatic logic signed [15:0] mixed_sample();
        int sum;
        sum = 0;
        for (int v = 0; v < NV; v++)
            if (!sh_ctrl[v & ~1][20]) sum += voice_output(v, 1'b0);
        if (sum < -32768) sum = -32768;
        if (sum > 32767) sum = 32767;
        return 16'(sum);
    endfunction

    // Apply one accepted request to the shadow state and queue its answer.
    function automatic void predict_answer(t_request r);
        t_answer ans;
        int vn;
        vn = int'(r.idx >> 2);
        ans = '0;
        case (r.mode)
            MODE_READ: if (vn < NV) begin
                case (r.idx[1:0])
                    BANK_CTRL: ans.rd = sh_ctrl[vn];
                    BANK_AUXB: ans.rd = sh_auxb[vn];
                    BANK_AUXC: ans.rd = sh_auxc[vn];
                    default:   ans.rd = sh_acc[vn] & 32'h000F_FFFF;
                endcase
            end
            MODE_WRITE: if (vn < NV) begin
                case (r.idx[1:0])
                    BANK_CTRL: sh_ctrl[vn] = r.val;
                    BANK_AUXB: sh_auxb[vn] = r.val;
                    BANK_AUXC: sh_auxc[vn] = r.val;
                    default:   sh_acc[vn] = r.val;
                endcase
            end
            MODE_TICK16, MODE_TICK32, MODE_TICK0: begin
                if (r.mode == MODE_TICK16) step_phases(2);
                else if (r.mode == MODE_TICK32) step_phases(1);
                ans.smp = mixed_sample();
            end
            default: ;
        endcase
        expected_answers.push_back(ans);
    endfunction

    function automatic void add_req(logic [2:0] mode, logic [6:0] idx, logic [31:0] val);
        t_request r;
        r.mode = mode;
        r.idx  = idx;
        r.val  = val;
        pending_reqs.push_back(r);
    endfunction

    // A control word with random shape and attenuation, and random FM/PCM bits.
    function automatic logic [31:0] rand_ctrl();
        logic [31:0] c;
        c = $urandom;
        c[20] = ($urandom_range(0, 3) == 0);
        c[21] = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) != 0) c[27:25] = 3'($urandom_range(0, 2));
        return c;
    endfunction

    // Random request: mostly ticks and control/phase writes that make voices sound.
    function automatic void add_random();
        int k;
        k = $urandom_range(0, 99);
        if (k < 30)
            add_req(3'($urandom_range(MODE_TICK16, MODE_TICK0)), 7'($urandom), $urandom);
        else if (k < 55)
            add_req(MODE_WRITE, 7'({$urandom_range(0, 31), 2'(BANK_CTRL)}), rand_ctrl());
        else if (k < 65)
            add_req(MODE_WRITE, 7'({$urandom_range(0, 31), 2'(BANK_ACC)}), $urandom);
        else if (k < 72)
            add_req(MODE_WRITE, 7'($urandom), $urandom);
        else if (k < 95)
            add_req(MODE_READ, 7'($urandom), $urandom);
        else
            add_req(3'($urandom_range(5, 7)), 7'($urandom), $urandom);
    endfunction

    // Driver: presents queued requests, with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid       <= 1'b0;
            i_mode        <= '0;
            i_reg_index   <= '0;
            i_write_value <= '0;
            drv_gap       <= 0;
        end else if (!i_valid || o_ready) begin
            // The previous request (if any) has just been accepted.
            if (i_valid) predict_answer({i_mode, i_reg_index, i_write_value});
            if (drv_gap > 0) begin
                drv_gap <= drv_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !hold_sender) begin
                t_request r;
                r = pending_reqs.pop_front();
                i_valid       <= 1'b1;
                i_mode        <= r.mode;
                i_reg_index   <= r.idx;
                i_write_value <= r.val;
                if (!calm && $urandom_range(0, 5) == 0) drv_gap <= $urandom_range(1, 4);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: stalls at random, compares each delivered answer with the oldest one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            mon_stall <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_answers.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_ERRS)
                        $display("unexpected answer rd=%h smp=%0d", o_read_data, o_mix_sample);
                end else begin
                    t_answer e;
                    e = expected_answers.pop_front();
                    if (e.rd !== o_read_data || e.smp !== o_mix_sample) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < MAX_ERRS)
                            $display("mismatch: expected rd=%h smp=%0d, got rd=%h smp=%0d",
                                     e.rd, e.smp, o_read_data, o_mix_sample);
                    end
                end
            end
            if (mon_stall > 0) begin
                mon_stall <= mon_stall - 1;
                i_ready   <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                mon_stall <= $urandom_range(0, 3);
                i_ready   <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        mismatches  = 0;
        cycle_count = 0;
        stim_done   = 1'b0;
        calm        = 1'b0;
        hold_sender = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_mode      = '0;
        i_reg_index = '0;
        i_write_value = '0;
        for (int v = 0; v < NV; v++) begin
            sh_ctrl[v] = '0; sh_auxb[v] = '0; sh_auxc[v] = '0; sh_acc[v] = '0;
        end

        // Directed part: each bank, extremes, every mode, special voice setups.
        add_req(MODE_TICK0, 7'h00, 32'h0);                  // all silent
        add_req(MODE_WRITE, 7'h01, 32'hFFFF_FFFF);          // aux b
        add_req(MODE_WRITE, 7'h7E, 32'hA5A5_5A5A);          // aux c, last voice
        add_req(MODE_READ,  7'h01, 32'h0);
        add_req(MODE_READ,  7'h7E, 32'h0);
        add_req(MODE_WRITE, 7'h03, 32'hFFFF_FFFF);          // accumulator wrap
        add_req(MODE_READ,  7'h03, 32'h0);                  // masked to 20 bits
        add_req(MODE_WRITE, 7'h00, 32'h5000_1234);          // saw voice 0
        add_req(MODE_WRITE, 7'h7C, 32'h6FC0_0001);          // last voice, muted
        add_req(MODE_TICK16, 7'h00, 32'h0);
        add_req(MODE_TICK32, 7'h00, 32'h0);
        add_req(MODE_WRITE, 7'h08, 32'h0013_0000);          // pair 2 carry mode
        add_req(MODE_WRITE, 7'h0C, 32'h1010_0100);          // odd carries down
        add_req(MODE_TICK16, 7'h00, 32'h0);
        add_req(MODE_READ,  7'h0F, 32'h0);
        add_req(MODE_WRITE, 7'h10, 32'h7020_4000);          // FM carrier voice 4
        add_req(MODE_WRITE, 7'h14, 32'h2000_3000);          // modulator voice 5
        add_req(MODE_TICK32, 7'h00, 32'h0);
        for (int v = 8; v < 16; v++) add_req(MODE_WRITE, 7'(v * 4), 32'h3000_FFFF);
        add_req(MODE_TICK16, 7'h00, 32'h0);                 // clamps high
        add_req(3'd7, 7'h7F, 32'hFFFF_FFFF);                // unused mode
        add_req(3'd5, 7'h00, 32'h0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_reqs.size() == 0);
        // Hold the sender until every outstanding answer has been delivered.
        @(posedge i_clk);
        hold_sender = 1'b1;
        wait (!i_valid && expected_answers.size() == 0);
        @(posedge i_clk);
        hold_sender = 1'b0;

        for (int n = 0; n < N_RANDOM; n++) begin
            add_random();
            if (n == N_RANDOM * 9 / 10) begin
                wait (pending_reqs.size() < 4);
                calm = 1'b1;
            end
            if (pending_reqs.size() > 32) wait (pending_reqs.size() < 8);
        end
        wait (pending_reqs.size() == 0 && !i_valid && expected_answers.size() == 0);
        repeat (400) @(posedge i_clk);
        if (mismatches == 0 && expected_answers.size() == 0) $display("tb_top passed");
        else $display("tb_top failed");
        $finish;
    end
endmodule
